@@ rtl/fir_pkg.sv @@
// Shared constants, command/status structs for the Q15 FIR filter.
// Used by fir_ctrl, fir_dp and the fir_filter_q15 top level.
`timescale 1ns / 1ps
`default_nettype none

package fir_pkg;

    localparam int DELAY_DEPTH_DEF = 64;
    localparam int NUM_COEFS       = 64;
    localparam int COEF_AW         = 6;
    localparam int TAPS_W          = 7;
    localparam int SAMPLE_W        = 16;
    localparam int ACC_W           = 32;
    localparam int Q_SHIFT         = 15;
    localparam int S_TDATA_W       = 40;

    localparam logic [TAPS_W-1:0] NUM_TAPS_RST = 7'd64;

    // s_tdata layout, lowest bit first: sample, coef_index, coef_value
    localparam int SAMPLE_LSB = 0;
    localparam int CIDX_LSB   = 16;
    localparam int CVAL_LSB   = 22;

    typedef struct packed {
        logic clear;     // zero one entry of both tables
        logic coef_wr;   // load a coefficient from the input beat
        logic samp_wr;   // store a sample, start a new convolution
        logic issue;     // read one tap pair
        logic load_out;  // move the accumulator into the output register
    } fir_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic last_tap;
        logic taps_zero;
        logic pipe_busy;
        logic out_free;
    } fir_sts_t;

endpackage

`default_nettype wire

@@ rtl/fir_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fir_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/fir_ctrl.sv @@
// Sequencing FSM for the FIR filter: clear pass, accept, MAC loop, drain, output.
// Depends on fir_pkg; drives fir_dp through fir_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module fir_ctrl
    import fir_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    input  wire logic     s_tuser,
    output logic          s_tready,
    input  wire fir_sts_t sts,
    output fir_cmd_t      cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd          = '0;
        cmd.clear    = (state_reg == ST_CLEAR);
        cmd.coef_wr  = accept && s_tuser;
        cmd.samp_wr  = accept && !s_tuser;
        cmd.issue    = (state_reg == ST_MAC);
        cmd.load_out = (state_reg == ST_DONE) && sts.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cmd.samp_wr) begin
                    state_next = sts.taps_zero ? ST_DONE : ST_MAC;
                end
            end
            ST_MAC: begin
                if (sts.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fir_dp.sv @@
// FIR datapath: delay line and coefficient RAMs, pointers, one multiplier,
// 32-bit accumulator, tap-count register and output register.
// Depends on fir_pkg and fir_ram.
`timescale 1ns / 1ps
`default_nettype none

module fir_dp
    import fir_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire fir_cmd_t              cmd,
    output fir_sts_t                   sts,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [TAPS_W-1:0]     cfg_data,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [SAMPLE_W-1:0]        m_tdata
);

    localparam int AW      = $clog2(DELAY_DEPTH);
    localparam int CLR_LEN = (DELAY_DEPTH > NUM_COEFS) ? DELAY_DEPTH : NUM_COEFS;
    localparam int CLRW    = $clog2(CLR_LEN);

    logic [TAPS_W-1:0]   num_taps_reg;
    logic [CLRW-1:0]     clr_cnt_reg;
    logic [AW-1:0]       wp_reg, wp_inc;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_dec;
    logic [COEF_AW-1:0]  k_reg;
    logic [COEF_AW-1:0]  taps_m1_reg;
    logic [TAPS_W-1:0]   taps_sat;
    logic                rv_reg, pv_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic [ACC_W-1:0]    acc_reg;

    logic                dl_we, cf_we;
    logic [AW-1:0]       dl_waddr;
    logic [SAMPLE_W-1:0] dl_wdata, dl_rdata;
    logic [COEF_AW-1:0]  cf_waddr;
    logic [SAMPLE_W-1:0] cf_wdata, cf_rdata;

    assign cfg_ready = 1'b1;

    assign wp_inc     = (wp_reg == AW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rd_ptr_dec = (rd_ptr_reg == '0) ? AW'(DELAY_DEPTH - 1) : rd_ptr_reg - 1'b1;
    assign taps_sat   = (num_taps_reg > TAPS_W'(NUM_COEFS)) ? TAPS_W'(NUM_COEFS)
                                                            : num_taps_reg;

    // Both tables are swept with zeros after reset.
    assign dl_we    = cmd.clear || cmd.samp_wr;
    assign dl_waddr = cmd.clear ? clr_cnt_reg[AW-1:0] : wp_inc;
    assign dl_wdata = cmd.clear ? '0 : s_tdata[SAMPLE_LSB +: SAMPLE_W];

    assign cf_we    = cmd.clear || cmd.coef_wr;
    assign cf_waddr = cmd.clear ? clr_cnt_reg[COEF_AW-1:0] : s_tdata[CIDX_LSB +: COEF_AW];
    assign cf_wdata = cmd.clear ? '0 : s_tdata[CVAL_LSB +: SAMPLE_W];

    fir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_delay_ram (
        .aclk  (aclk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (rd_ptr_reg),
        .rdata (dl_rdata)
    );

    fir_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NUM_COEFS)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (cf_we),
        .waddr (cf_waddr),
        .wdata (cf_wdata),
        .raddr (k_reg),
        .rdata (cf_rdata)
    );

    always_comb begin
        sts            = '0;
        sts.clear_done = (clr_cnt_reg == CLRW'(CLR_LEN - 1));
        sts.last_tap   = (k_reg == taps_m1_reg);
        sts.taps_zero  = (num_taps_reg == '0);
        sts.pipe_busy  = rv_reg || pv_reg;
        sts.out_free   = !m_tvalid || m_tready;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_taps_reg <= NUM_TAPS_RST;
            clr_cnt_reg  <= '0;
            wp_reg       <= '0;
            rv_reg       <= 1'b0;
            pv_reg       <= 1'b0;
            m_tvalid     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                num_taps_reg <= cfg_data;
            end
            if (cmd.clear) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.samp_wr) begin
                wp_reg <= wp_inc;
            end
            rv_reg <= cmd.issue;
            pv_reg <= rv_reg;
            if (cmd.load_out) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.samp_wr) begin
            rd_ptr_reg  <= wp_inc;
            k_reg       <= '0;
            taps_m1_reg <= COEF_AW'(taps_sat - 1'b1);
        end else if (cmd.issue) begin
            rd_ptr_reg <= rd_ptr_dec;
            k_reg      <= k_reg + 1'b1;
        end
        prod_reg <= $signed(cf_rdata) * $signed(dl_rdata);
        if (cmd.samp_wr) begin
            acc_reg <= '0;
        end else if (pv_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
        if (cmd.load_out) begin
            m_tdata <= acc_reg[Q_SHIFT +: SAMPLE_W];
        end
    end

    a_no_write_during_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !(cmd.samp_wr || cmd.coef_wr || cmd.clear))
        else $error("table write while taps are being read");

    a_load_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(rv_reg || pv_reg))
        else $error("result loaded before the MAC pipeline drained");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_tvalid)
        else $error("loaded result not presented");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while a beat waits");

endmodule

`default_nettype wire

@@ rtl/fir_filter_q15.sv @@
// Q15 direct-form FIR filter, circular delay line, one MAC per cycle.
// Coefficient write: accepted in one cycle, no result beat; writes can follow back to back.
// Sample: result beat can be taken num_taps + 5 cycles after accept (num_taps capped at 64,
//   zero taps give 2); the next beat is taken no sooner, later while m_tready holds it off.
// Reset: aresetn low clears control; then a clearing pass of max(DELAY_DEPTH, 64) cycles
//   zeros both tables, during which s_tready stays low (configuration writes still taken).
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_q15
    import fir_pkg::*;
#(
    parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration: num_taps
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [TAPS_W-1:0]    cfg_data,
    // input beats
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // sample[15:0], coef_index[21:16], coef_value[37:22]
    input  wire logic                 s_tuser,   // req_type
    // result beats
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [SAMPLE_W-1:0]       m_tdata    // filtered[15:0]
);

    fir_cmd_t cmd;
    fir_sts_t sts;

    fir_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fir_dp #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
